// ----- rtl/a2nv_pkg.sv -----
// Shared types, constants and sample arithmetic for the ARGB to NV21 converter.
`timescale 1ns / 1ps
`default_nettype none

package a2nv_pkg;

    // Field and register widths
    localparam int ADDR_W         = 24;
    localparam int PIX_W          = 32;
    localparam int BYTE_W         = 8;
    localparam int CFG_DATA_W     = 13;
    localparam int FRAME_WIDTH_W  = 13;
    localparam int FRAME_HEIGHT_W = 12;
    localparam int CFG_IDX_W      = 2;
    // Wide enough to compare either dimension register against any size limit
    localparam int DIM_CMP_W      = 14;

    // Size limits and command queue depth
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int CMD_DEPTH      = 2;

    // Register reset values
    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 13'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    // BT.601 integer coefficients
    localparam logic signed [17:0] C_YR  = 18'sd66;
    localparam logic signed [17:0] C_YG  = 18'sd129;
    localparam logic signed [17:0] C_YB  = 18'sd25;
    localparam logic signed [17:0] C_UR  = -18'sd38;
    localparam logic signed [17:0] C_UG  = -18'sd74;
    localparam logic signed [17:0] C_UB  = 18'sd112;
    localparam logic signed [17:0] C_VR  = 18'sd112;
    localparam logic signed [17:0] C_VG  = -18'sd94;
    localparam logic signed [17:0] C_VB  = -18'sd18;
    localparam logic signed [17:0] C_RND = 18'sd128;
    localparam logic signed [9:0]  OFS_Y = 10'sd16;
    localparam logic signed [9:0]  OFS_C = 10'sd128;
    localparam logic signed [9:0]  SAMPLE_MAX = 10'sd255;

    // One pixel's work as handed from the front end to the back end
    typedef struct packed {
        logic [ADDR_W-1:0] luma_addr;
        logic [ADDR_W-1:0] chroma_addr;
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] v;
        logic [BYTE_W-1:0] u;
        logic              has_chroma;
        logic              eof;
    } a2nv_cmd_t;

    // Floor-shift a weighted sum by 8, add the offset and clamp to a byte
    function automatic logic [BYTE_W-1:0] clamp_sample(
        input logic signed [17:0] sum,
        input logic signed [9:0]  offset
    );
        logic signed [17:0] shifted;
        logic signed [9:0]  t;
        shifted = sum >>> 8;
        t = $signed(shifted[9:0]) + offset;
        if (t < 10'sd0) begin
            return '0;
        end else if (t > SAMPLE_MAX) begin
            return '1;
        end else begin
            return t[BYTE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/a2nv_cmd_fifo.sv -----
// Short register queue of pixel commands between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module a2nv_cmd_fifo
    import a2nv_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire a2nv_cmd_t wr_data,
    output logic           full,
    input  wire logic      rd_en,
    output a2nv_cmd_t      rd_data,
    output logic           empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    a2nv_cmd_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the written command
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/a2nv_front.sv -----
// Front end: frame registers, raster position tracking and color conversion.
`timescale 1ns / 1ps
`default_nettype none

module a2nv_front
    import a2nv_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [PIX_W-1:0]      pixel_argb,
    input  wire logic                  cmd_full,
    output logic                       cmd_push,
    output a2nv_cmd_t                  cmd
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [COL_W-1:0]          col_reg, col_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic [ADDR_W-1:0]         luma_reg, luma_next;
    logic [ADDR_W-1:0]         chroma_reg, chroma_next;
    logic [ADDR_W-1:0]         plane_size_reg, plane_size_next;
    logic                      restart_reg, restart_next;
    logic [WW-1:0]             eff_w;
    logic [HW-1:0]             eff_h;
    logic [WW+HW-1:0]          plane_prod;
    logic                      cfg_hit, accept, last_col, last_row, has_chroma;
    logic signed [17:0]        rs, gs, bs;
    logic signed [17:0]        sum_y, sum_u, sum_v;

    // Saturate the frame size to 1..limit
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (DIM_CMP_W'(frame_width_reg) > DIM_CMP_W'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(frame_width_reg);
        end
        if (frame_height_reg == '0)
        begin
            eff_h = HW'(1);
        end
        else if (DIM_CMP_W'(frame_height_reg) > DIM_CMP_W'(MAX_HEIGHT))
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HW'(frame_height_reg);
        end
    end

    assign plane_prod      = eff_w * eff_h;
    assign plane_size_next = ADDR_W'(plane_prod);

    // Hold off requests while the queue is full or the plane size settles after a restart
    assign full     = cmd_full || restart_reg;
    assign accept   = push && !full;
    assign cmd_push = accept;
    assign cfg_hit  = cfg_write &&
                      (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    // Classify the raster position
    assign last_col   = (WW'(col_reg) + 1'b1 == eff_w);
    assign last_row   = (HW'(row_reg) + 1'b1 == eff_h);
    assign has_chroma = !col_reg[0] && !row_reg[0];

    // Convert the pixel
    assign rs    = $signed({10'b0, pixel_argb[23:16]});
    assign gs    = $signed({10'b0, pixel_argb[15:8]});
    assign bs    = $signed({10'b0, pixel_argb[7:0]});
    assign sum_y = C_YR * rs + C_YG * gs + C_YB * bs + C_RND;
    assign sum_u = C_UR * rs + C_UG * gs + C_UB * bs + C_RND;
    assign sum_v = C_VR * rs + C_VG * gs + C_VB * bs + C_RND;

    always_comb
    begin
        cmd.luma_addr   = luma_reg;
        cmd.chroma_addr = chroma_reg;
        cmd.y           = clamp_sample(sum_y, OFS_Y);
        cmd.u           = clamp_sample(sum_u, OFS_C);
        cmd.v           = clamp_sample(sum_v, OFS_C);
        cmd.has_chroma  = has_chroma;
        cmd.eof         = last_col && last_row;
    end

    // Frame registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= FRAME_HEIGHT_W'(cfg_data);
                default:          ;
            endcase
        end
    end

    // Advance the raster position and plane addresses
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        luma_next    = luma_reg;
        chroma_next  = chroma_reg;
        restart_next = restart_reg;
        if (cfg_hit)
        begin
            col_next     = '0;
            row_next     = '0;
            luma_next    = '0;
            restart_next = 1'b1;
        end
        else if (restart_reg)
        begin
            chroma_next  = plane_size_next;
            restart_next = 1'b0;
        end
        else if (accept)
        begin
            luma_next = luma_reg + 1'b1;
            if (has_chroma)
            begin
                chroma_next = chroma_reg + ADDR_W'(2);
            end
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next    = '0;
                    luma_next   = '0;
                    chroma_next = plane_size_reg;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            luma_reg    <= '0;
            chroma_reg  <= '0;
            restart_reg <= 1'b1;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            luma_reg    <= luma_next;
            chroma_reg  <= chroma_next;
            restart_reg <= restart_next;
        end
    end

    // Capture the plane size during a restart
    always_ff @(posedge clk)
    begin
        if (restart_reg)
        begin
            plane_size_reg <= plane_size_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/a2nv_back.sv -----
// Back end: serializes each pixel command into its Y byte and, on chroma sites, V and U bytes.
`timescale 1ns / 1ps
`default_nettype none

module a2nv_back
    import a2nv_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire a2nv_cmd_t    cmd,
    input  wire logic         cmd_empty,
    output logic              cmd_pop,
    output logic              empty,
    input  wire logic         pop,
    output logic [ADDR_W-1:0] byte_address,
    output logic [BYTE_W-1:0] byte_value,
    output logic              last_of_pixel,
    output logic              end_of_frame
);

    typedef enum logic [1:0] {
        PH_LUMA,
        PH_V,
        PH_U
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] addr_reg, addr_sel;
    logic [BYTE_W-1:0] value_reg, value_sel;
    logic              last_reg, last_sel;
    logic              eof_reg, eof_sel;
    logic              load, issue;

    // Load the output stage when it is free or being drained
    assign load    = !out_valid_reg || pop;
    assign issue   = load && !cmd_empty;
    assign cmd_pop = issue && last_sel;

    assign empty         = !out_valid_reg;
    assign byte_address  = addr_reg;
    assign byte_value    = value_reg;
    assign last_of_pixel = last_reg;
    assign end_of_frame  = eof_reg;

    // Pick the byte for the current phase
    always_comb
    begin
        unique case (phase_reg)
            PH_V:
            begin
                addr_sel   = cmd.chroma_addr;
                value_sel  = cmd.v;
                last_sel   = 1'b0;
                eof_sel    = 1'b0;
                phase_next = PH_U;
            end
            PH_U:
            begin
                addr_sel   = cmd.chroma_addr + 1'b1;
                value_sel  = cmd.u;
                last_sel   = 1'b1;
                eof_sel    = cmd.eof;
                phase_next = PH_LUMA;
            end
            default:
            begin
                addr_sel   = cmd.luma_addr;
                value_sel  = cmd.y;
                last_sel   = !cmd.has_chroma;
                eof_sel    = !cmd.has_chroma && cmd.eof;
                phase_next = cmd.has_chroma ? PH_V : PH_LUMA;
            end
        endcase
    end

    // Hold phase and output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LUMA;
            out_valid_reg <= 1'b0;
            addr_reg      <= '0;
            value_reg     <= '0;
            last_reg      <= 1'b0;
            eof_reg       <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= issue;
            if (issue)
            begin
                phase_reg <= phase_next;
                addr_reg  <= addr_sel;
                value_reg <= value_sel;
                last_reg  <= last_sel;
                eof_reg   <= eof_sel;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/argb_to_nv21_converter_unit.sv -----
// Top level of the ARGB to NV21 converter: front end, command queue, back end.
//
//  Channel   Direction  Handshake           Payload
//  -------   ---------  ------------------  ---------------------------------------------
//  pixel     in         push / full         pixel_argb
//  byte      out        empty / pop         byte_address, byte_value, last_of_pixel,
//                                           end_of_frame
//  config    in         cfg_write           cfg_index, cfg_data
//
// A pixel request is taken whenever full is low; the front end converts it and queues it.
// The back end sends one byte per cycle through a single output register while the byte
// side keeps popping; a pixel on an even row and column gives its Y, V and U bytes and any
// other only its Y byte, so the output byte port limits the pixel throughput.
// After reset and after any write to a frame register, full is held high while the
// chroma plane base (width times height) is computed.
// Either side may stall independently; the two-entry queue decouples them.
`timescale 1ns / 1ps
`default_nettype none

module argb_to_nv21_converter_unit
    import a2nv_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [PIX_W-1:0]      pixel_argb,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [ADDR_W-1:0]          byte_address,
    output logic [BYTE_W-1:0]          byte_value,
    output logic                       last_of_pixel,
    output logic                       end_of_frame
);

    a2nv_cmd_t cmd_in, cmd_out;
    logic      cmd_push, cmd_full, cmd_pop, cmd_empty;

    a2nv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .pixel_argb (pixel_argb),
        .cmd_full   (cmd_full),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    a2nv_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    a2nv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_out),
        .cmd_empty     (cmd_empty),
        .cmd_pop       (cmd_pop),
        .empty         (empty),
        .pop           (pop),
        .byte_address  (byte_address),
        .byte_value    (byte_value),
        .last_of_pixel (last_of_pixel),
        .end_of_frame  (end_of_frame)
    );

    // Frame end is only flagged on the closing byte of a pixel
    a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && end_of_frame) |-> last_of_pixel)
        else $error("end_of_frame without last_of_pixel");

    // A frame register write blocks requests on the next cycle
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT))
        |=> full)
        else $error("request window open right after a frame register write");

    // The command queue cannot be both full and empty
    a_cmd_queue: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_full && cmd_empty))
        else $error("command queue full and empty at once");

    // The back end never takes a command from an empty queue
    a_cmd_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command taken from empty queue");

endmodule

`default_nettype wire

// ----- tb/sv/tb_argb_to_nv21_converter_unit.sv -----
// Self-checking testbench for the ARGB to NV21 converter: directed table, random frames.
`timescale 1ns / 1ps

module tb_argb_to_nv21_converter_unit;
    import a2nv_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PIXELS = 140;
    localparam int HOLD_CYCLES   = 80;
    localparam int TAIL_CYCLES   = 20;
    localparam int IDLE_PCT      = 7;
    localparam int STEADY_PHASE  = 2;
    localparam int HOLD_PHASE    = 3;
    localparam int BURST_PIXELS  = 40;
    localparam int MAX_PRINTS    = 100;

    // Register indexes past the end of the list; writes there change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

    typedef struct {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [PIX_W-1:0]     data;
        bit                   known;
        logic [BYTE_W-1:0]    y;
        logic [BYTE_W-1:0]    v;
        logic [BYTE_W-1:0]    u;
    } step_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] value;
        logic              last;
        logic              eof;
    } nv21_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [PIX_W-1:0]      pixel_argb = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [ADDR_W-1:0]     byte_address;
    logic [BYTE_W-1:0]     byte_value;
    logic                  last_of_pixel;
    logic                  end_of_frame;

    // Shared control between the request side and the byte side
    bit steady = 1'b0;
    bit hold_off_req = 1'b0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // Predictor state and its copy of the frame registers
    logic [FRAME_WIDTH_W-1:0]  frame_w_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_h_reg;
    logic [11:0]               col_pos;
    logic [10:0]               row_pos;
    logic [ADDR_W-1:0]         luma_ptr;
    logic [ADDR_W-1:0]         chroma_ptr;

    nv21_byte_t pending_bytes[$];
    step_t      directed_steps[$];

    argb_to_nv21_converter_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .pixel_argb   (pixel_argb),
        .empty        (empty),
        .pop          (pop),
        .byte_address (byte_address),
        .byte_value   (byte_value),
        .last_of_pixel(last_of_pixel),
        .end_of_frame (end_of_frame)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("argb_to_nv21_converter_unit test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h (cycle %0d)",
                     what, got, want, cycle_count);
    endtask

    // Saturate the frame registers to the legal frame size
    function automatic int unsigned active_width();
        if (frame_w_reg == 0) return 1;
        if (frame_w_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return frame_w_reg;
    endfunction

    function automatic int unsigned active_height();
        if (frame_h_reg == 0) return 1;
        if (frame_h_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
        return frame_h_reg;
    endfunction

    task automatic restart_frame_model();
        col_pos    = '0;
        row_pos    = '0;
        luma_ptr   = '0;
        chroma_ptr = ADDR_W'(active_width() * active_height());
    endtask

    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH:
            begin
                frame_w_reg = data[FRAME_WIDTH_W-1:0];
                restart_frame_model();
            end
            REG_FRAME_HEIGHT:
            begin
                frame_h_reg = data[FRAME_HEIGHT_W-1:0];
                restart_frame_model();
            end
            default:
            begin
            end
        endcase
    endtask

    // Floor-divide the weighted sum by 256, add the offset, clamp to a byte
    function automatic logic [BYTE_W-1:0] clamp_byte(input int acc, input int offset);
        int t;
        t = (acc >>> 8) + offset;
        if (t < 0) return '0;
        if (t > 255) return 8'd255;
        return t[BYTE_W-1:0];
    endfunction

    task automatic expect_byte(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] value,
                               input logic last, input logic eof);
        nv21_byte_t ent;
        ent.addr  = addr;
        ent.value = value;
        ent.last  = last;
        ent.eof   = eof;
        pending_bytes.push_back(ent);
    endtask

    // Queue the bytes one pixel produces and advance the raster position
    task automatic predict_nv21_bytes(input logic [PIX_W-1:0] px, input bit known,
                                      input logic [BYTE_W-1:0] ky,
                                      input logic [BYTE_W-1:0] kv,
                                      input logic [BYTE_W-1:0] ku);
        int r;
        int g;
        int b;
        bit last_col;
        bit last_row;
        bit eof;
        bit chroma_site;
        logic [BYTE_W-1:0] y_val;
        logic [BYTE_W-1:0] v_val;
        logic [BYTE_W-1:0] u_val;
        r = px[23:16];
        g = px[15:8];
        b = px[7:0];
        last_col    = (int'(col_pos) + 1 >= int'(active_width()));
        last_row    = (int'(row_pos) + 1 >= int'(active_height()));
        eof         = last_col && last_row;
        chroma_site = !col_pos[0] && !row_pos[0];
        y_val = clamp_byte(66 * r + 129 * g + 25 * b + 128, 16);
        v_val = clamp_byte(112 * r - 94 * g - 18 * b + 128, 128);
        u_val = clamp_byte(-38 * r - 74 * g + 112 * b + 128, 128);
        if (known)
        begin
            y_val = ky;
            v_val = kv;
            u_val = ku;
        end
        if (chroma_site)
        begin
            expect_byte(luma_ptr, y_val, 1'b0, 1'b0);
            expect_byte(chroma_ptr, v_val, 1'b0, 1'b0);
            expect_byte(chroma_ptr + 24'd1, u_val, 1'b1, eof);
            chroma_ptr = chroma_ptr + 24'd2;
        end
        else
        begin
            expect_byte(luma_ptr, y_val, 1'b1, eof);
        end
        luma_ptr = luma_ptr + 24'd1;
        if (last_col)
        begin
            col_pos = '0;
            if (last_row)
                restart_frame_model();
            else
                row_pos = row_pos + 11'd1;
        end
        else
        begin
            col_pos = col_pos + 12'd1;
        end
    endtask

    // Drop the request and wait until every queued byte has come out
    task automatic wait_until_drained();
        push <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_until_drained();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg_write(idx, data);
    endtask

    // Offer one pixel request, idling at random first, and hold it until taken
    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit known,
                              input logic [BYTE_W-1:0] ky,
                              input logic [BYTE_W-1:0] kv,
                              input logic [BYTE_W-1:0] ku);
        cfg_write <= 1'b0;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        pixel_argb <= px;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_nv21_bytes(px, known, ky, kv, ku);
    endtask

    task automatic add_pixel_row(input logic [PIX_W-1:0] px, input bit known,
                                 input logic [BYTE_W-1:0] ky,
                                 input logic [BYTE_W-1:0] kv,
                                 input logic [BYTE_W-1:0] ku);
        step_t s;
        s.kind      = STEP_PIXEL;
        s.reg_index = '0;
        s.data      = px;
        s.known     = known;
        s.y         = ky;
        s.v         = kv;
        s.u         = ku;
        directed_steps.push_back(s);
    endtask

    task automatic add_write_row(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        step_t s;
        s.kind      = STEP_WRITE;
        s.reg_index = idx;
        s.data      = PIX_W'(data);
        s.known     = 1'b0;
        s.y         = '0;
        s.v         = '0;
        s.u         = '0;
        directed_steps.push_back(s);
    endtask

    task automatic check_byte();
        nv21_byte_t want;
        if (pending_bytes.size() == 0)
        begin
            report_mismatch("byte with no request pending", 32'(byte_address), 32'd0);
            return;
        end
        want = pending_bytes.pop_front();
        if (byte_address !== want.addr)
            report_mismatch("byte_address", 32'(byte_address), 32'(want.addr));
        if (byte_value !== want.value)
            report_mismatch("byte_value", 32'(byte_value), 32'(want.value));
        if (last_of_pixel !== want.last)
            report_mismatch("last_of_pixel", 32'(last_of_pixel), 32'(want.last));
        if (end_of_frame !== want.eof)
            report_mismatch("end_of_frame", 32'(end_of_frame), 32'(want.eof));
    endtask

    // Byte side: take bytes with random stalls, plus one long hold-off on request
    initial
    begin
        int held;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                check_byte();
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                pop <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                pop <= 1'b1;
            end
            else
            begin
                pop <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Request side: directed table, then random frames
    initial
    begin
        int i;
        int phase;
        int sent;
        int count;
        bit extreme;
        step_t s;
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] hdata;

        frame_w_reg = FRAME_WIDTH_RST;
        frame_h_reg = FRAME_HEIGHT_RST;
        restart_frame_model();

        // Primaries and extremes at the default frame size, straight after reset
        add_pixel_row(32'h0000_0000, 1'b1, 8'd16, 8'd128, 8'd128);
        add_pixel_row(32'hFFFF_FFFF, 1'b1, 8'd235, 8'd128, 8'd128);
        add_pixel_row(32'h00FF_0000, 1'b1, 8'd82, 8'd240, 8'd90);
        add_pixel_row(32'h0000_FF00, 1'b1, 8'd144, 8'd34, 8'd54);
        add_pixel_row(32'h0000_00FF, 1'b1, 8'd41, 8'd110, 8'd240);
        add_pixel_row(32'hAA55_AA55, 1'b0, 8'd0, 8'd0, 8'd0);
        add_pixel_row(32'h55AA_55AA, 1'b0, 8'd0, 8'd0, 8'd0);
        // Odd width and height: last column and row still carry chroma; frame wraps
        add_write_row(REG_FRAME_WIDTH, 13'd3);
        add_write_row(REG_FRAME_HEIGHT, 13'd3);
        for (i = 0; i < 11; i++)
            add_pixel_row(32'h9E37_79B9 * (i + 1), 1'b0, 8'd0, 8'd0, 8'd0);
        // Writes past the register list must not restart the frame
        add_write_row(REG_SPARE_2, 13'd5);
        add_write_row(REG_SPARE_3, 13'h1FFF);
        add_pixel_row(32'h1234_5678, 1'b0, 8'd0, 8'd0, 8'd0);
        add_pixel_row(32'hFEDC_BA98, 1'b0, 8'd0, 8'd0, 8'd0);
        // Zero dimensions saturate to one pixel: each pixel is a whole frame
        add_write_row(REG_FRAME_WIDTH, 13'd0);
        add_write_row(REG_FRAME_HEIGHT, 13'd0);
        add_pixel_row(32'h0000_0000, 1'b1, 8'd16, 8'd128, 8'd128);
        add_pixel_row(32'hFFFF_FFFF, 1'b1, 8'd235, 8'd128, 8'd128);
        // Oversized dimensions saturate to the largest frame
        add_write_row(REG_FRAME_WIDTH, 13'h1FFF);
        add_write_row(REG_FRAME_HEIGHT, 13'h1FFF);
        add_pixel_row(32'h8080_8080, 1'b0, 8'd0, 8'd0, 8'd0);
        add_write_row(REG_FRAME_WIDTH, 13'd4096);
        add_write_row(REG_FRAME_HEIGHT, 13'd2048);
        add_pixel_row(32'h7F7F_7F7F, 1'b0, 8'd0, 8'd0, 8'd0);
        // Single column: chroma on every other row
        add_write_row(REG_FRAME_WIDTH, 13'd1);
        add_write_row(REG_FRAME_HEIGHT, 13'd2);
        add_pixel_row(32'h00C0_4010, 1'b0, 8'd0, 8'd0, 8'd0);
        add_pixel_row(32'h0010_40C0, 1'b0, 8'd0, 8'd0, 8'd0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_steps[k])
        begin
            s = directed_steps[k];
            if (s.kind == STEP_WRITE)
                write_reg(s.reg_index, s.data[CFG_DATA_W-1:0]);
            else
                send_pixel(s.data, s.known, s.y, s.v, s.u);
        end

        // Random frames, mostly small so frame ends come often
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_PIXELS)
        begin
            phase++;
            steady  = (phase == STEADY_PHASE);
            extreme = (phase > HOLD_PHASE) && ($urandom_range(7) == 0);
            if (extreme)
            begin
                case ($urandom_range(3))
                    0: wdata = 13'd0;
                    1: wdata = 13'd1;
                    2: wdata = 13'd4096;
                    default: wdata = 13'h1FFF;
                endcase
                case ($urandom_range(3))
                    0: hdata = 13'd0;
                    1: hdata = 13'd1;
                    2: hdata = 13'd2048;
                    default: hdata = 13'h1FFF;
                endcase
                count = $urandom_range(2, 8);
            end
            else
            begin
                wdata = CFG_DATA_W'($urandom_range(1, 9));
                hdata = CFG_DATA_W'($urandom_range(1, 6));
                // Bit 12 of the height write lies beyond the register
                hdata[12] = ($urandom_range(3) == 0);
                count = $urandom_range(1, 24);
            end
            if (phase == STEADY_PHASE || phase == HOLD_PHASE)
                count = BURST_PIXELS;
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_DATA_W'($urandom()));
            if ($urandom_range(1))
            begin
                write_reg(REG_FRAME_WIDTH, wdata);
                write_reg(REG_FRAME_HEIGHT, hdata);
            end
            else
            begin
                write_reg(REG_FRAME_HEIGHT, hdata);
                write_reg(REG_FRAME_WIDTH, wdata);
            end
            // Stall the byte side so the block fills and pushes back
            if (phase == HOLD_PHASE)
                hold_off_req = 1'b1;
            for (i = 0; i < count; i++)
                send_pixel($urandom(), 1'b0, 8'd0, 8'd0, 8'd0);
            sent += count;
        end
        steady = 1'b0;

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("argb_to_nv21_converter_unit test passed");
        else
            $display("argb_to_nv21_converter_unit test failed");
        $finish;
    end

endmodule
